[rtl/jhs_pkg.sv]
// Shared types and constants for the Jacobi heat stencil sweep block.
package jhs_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 1024;

  localparam int TEMP_W      = 16;
  localparam int ROW_WIDTH_W = 11;
  localparam int ROW_COUNT_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(1000);
  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = ROW_COUNT_W'(1000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_WIDTH = 1'b0,
    CFG_ROW_COUNT = 1'b1
  } cfg_index_t;

  // Five old cells around the cell being produced.
  typedef struct packed {
    logic [TEMP_W-1:0] up;
    logic [TEMP_W-1:0] down;
    logic [TEMP_W-1:0] left;
    logic [TEMP_W-1:0] center;
    logic [TEMP_W-1:0] right;
  } window_t;

  typedef struct packed {
    logic step;     // an item advances the stream position
    logic wr_en;    // the item carries a cell to store
    logic restart;  // stream position returns to zero
  } lb_ctrl_t;

endpackage

[rtl/jhs_line_buffer.sv]
// Ring line store of two rows plus one cell and the stencil window taps.
module jhs_line_buffer
  import jhs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF,
  localparam int WW = $clog2(MAX_ROW_WIDTH + 1)
) (
  input  logic              clk,
  input  lb_ctrl_t          ctrl,
  input  logic [WW-1:0]     used_width,
  input  logic [WW-1:0]     restart_width,
  input  logic [TEMP_W-1:0] din,
  output window_t           win
);

  localparam int DEPTH = 2 * MAX_ROW_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [TEMP_W-1:0] mem [DEPTH];

  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] rptr, rptr_next;
  logic [AW-1:0] ring_last;

  logic [TEMP_W-1:0] rd_up, rd_right;
  logic [TEMP_W-1:0] down, center, left;

  // The ring holds 2*w+1 cells; the oldest one sits at the write pointer.
  assign ring_last = AW'({used_width, 1'b0});

  always_comb begin
    ptr_next  = ptr;
    rptr_next = rptr;
    if (ctrl.restart) begin
      ptr_next  = '0;
      rptr_next = AW'(restart_width) + AW'(1);
    end else if (ctrl.step) begin
      ptr_next  = (ptr == ring_last) ? '0 : ptr + AW'(1);
      rptr_next = (rptr == ring_last) ? '0 : rptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    rptr <= rptr_next;
  end

  // Reads are aimed at the next position so the data is ready when it is needed.
  always_ff @(posedge clk) begin
    rd_up    <= mem[ptr_next];
    rd_right <= mem[rptr_next];
    if (ctrl.wr_en) begin
      mem[ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      down   <= din;
      center <= rd_right;
      left   <= center;
    end
  end

  assign win.up     = rd_up;
  assign win.down   = down;
  assign win.left   = left;
  assign win.center = center;
  assign win.right  = rd_right;

endmodule

[rtl/jacobi_heat_stencil_sweep_top.sv]
// Top level of the Jacobi four-neighbor heat stencil sweep over a raster stream.
// One beat per cycle is taken unless the skid entry is full; the line store has one write
// and two read ports. A result is registered as its beat is accepted (into skid if held);
// in stream terms a cell leaves one row plus one cell after it enters.
// A two-entry output buffer keeps input flowing until both entries are full.
// Reset is synchronous: positions go to zero, registers to 1000; the store is not cleared.
module jacobi_heat_stencil_sweep_top
  import jhs_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TEMP_W-1:0]      s_tdata,   // temp_in
  input  logic                   s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TEMP_W-1:0]      m_tdata,   // temp_out
  output logic                   m_tlast,   // last
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CW = $clog2(MAX_ROW_WIDTH);

  function automatic logic [WW-1:0] clamp_width(input logic [ROW_WIDTH_W-1:0] rw);
    logic [WW-1:0] w;
    if (32'(rw) < 32'd3) begin
      w = WW'(3);
    end else if (32'(rw) > 32'(MAX_ROW_WIDTH)) begin
      w = WW'(MAX_ROW_WIDTH);
    end else begin
      w = WW'(rw);
    end
    return w;
  endfunction

  logic [ROW_WIDTH_W-1:0] row_width, row_width_next;
  logic [ROW_COUNT_W-1:0] row_count, row_count_next;

  logic [WW-1:0]          uw, uw_next;
  logic [CW-1:0]          wm1;
  logic [ROW_COUNT_W-1:0] uh, hm1;

  logic [CW-1:0]          in_col, in_col_next;
  logic [ROW_COUNT_W-1:0] in_row, in_row_next;
  logic                   in_done, in_done_next;
  logic                   primed, primed_next;
  logic [CW-1:0]          out_col, out_col_next;
  logic [ROW_COUNT_W-1:0] out_row, out_row_next;

  logic step, emit, last_cell, was_last, restart;
  lb_ctrl_t lb_ctrl;
  window_t  win;

  logic [TEMP_W+1:0] sum;
  logic [TEMP_W-1:0] res_temp;

  logic              out_valid, skid_valid;
  logic [TEMP_W-1:0] out_temp, skid_temp;
  logic              out_last, skid_last;
  logic              pop;

  // Configuration registers.
  always_comb begin
    row_width_next = row_width;
    row_count_next = row_count;
    if (rst) begin
      row_width_next = ROW_WIDTH_RESET;
      row_count_next = ROW_COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_ROW_WIDTH: row_width_next = cfg_data[ROW_WIDTH_W-1:0];
        CFG_ROW_COUNT: row_count_next = cfg_data[ROW_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    row_width <= row_width_next;
    row_count <= row_count_next;
  end

  assign uw      = clamp_width(row_width);
  assign uw_next = clamp_width(row_width_next);
  assign wm1     = CW'(uw - WW'(1));
  assign uh      = (row_count < ROW_COUNT_W'(3)) ? ROW_COUNT_W'(3) : row_count;
  assign hm1     = uh - ROW_COUNT_W'(1);

  // A flush before the grid is complete is dropped without moving anything.
  assign s_tready  = !skid_valid;
  assign step      = s_tvalid && s_tready && !(s_tuser && !in_done);
  assign emit      = step && primed;
  assign last_cell = (out_row == hm1) && (out_col == wm1);
  assign was_last  = emit && last_cell;
  assign restart   = rst || cfg_wr_en || was_last;

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    in_done_next = in_done;
    primed_next  = primed;
    out_col_next = out_col;
    out_row_next = out_row;
    if (step) begin
      if (in_row == ROW_COUNT_W'(1) && in_col == '0) begin
        primed_next = 1'b1;
      end
      if (in_col == wm1) begin
        in_col_next = '0;
        if (in_row == hm1) begin
          in_done_next = 1'b1;
        end else begin
          in_row_next = in_row + ROW_COUNT_W'(1);
        end
      end else begin
        in_col_next = in_col + CW'(1);
      end
    end
    if (emit) begin
      if (out_col == wm1) begin
        out_col_next = '0;
        out_row_next = out_row + ROW_COUNT_W'(1);
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
    if (restart) begin
      in_col_next  = '0;
      in_row_next  = '0;
      in_done_next = 1'b0;
      primed_next  = 1'b0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    in_col  <= in_col_next;
    in_row  <= in_row_next;
    in_done <= in_done_next;
    primed  <= primed_next;
    out_col <= out_col_next;
    out_row <= out_row_next;
  end

  assign lb_ctrl.step    = step;
  assign lb_ctrl.wr_en   = step && !s_tuser && !in_done;
  assign lb_ctrl.restart = restart;

  jhs_line_buffer #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_line_buffer (
    .clk          (clk),
    .ctrl         (lb_ctrl),
    .used_width   (uw),
    .restart_width(uw_next),
    .din          (s_tdata),
    .win          (win)
  );

  assign sum = {2'b00, win.up} + {2'b00, win.down} + {2'b00, win.left} + {2'b00, win.right};

  always_comb begin
    if (out_row == '0 || out_row == hm1 || out_col == '0 || out_col == wm1) begin
      res_temp = win.center;
    end else begin
      res_temp = sum[TEMP_W+1:2];
    end
  end

  // Output register with a skid entry behind it.
  assign pop = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= emit;
        end
      end else if (!out_valid) begin
        out_valid <= emit;
      end else if (emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_temp <= skid_temp;
      out_last <= skid_last;
    end else if (emit && (pop || !out_valid)) begin
      out_temp <= res_temp;
      out_last <= last_cell;
    end
    if (emit && out_valid && !pop) begin
      skid_temp <= res_temp;
      skid_last <= last_cell;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_temp;
  assign m_tlast  = out_last;

endmodule

[tb/jhs_tb_pkg.sv]
// Beat kinds shared by the stimulus and the checker of the heat stencil bench.
package jhs_tb_pkg;

  typedef enum logic {
    KIND_CELL  = 1'b0,
    KIND_FLUSH = 1'b1
  } cell_kind_t;

endpackage

[tb/jacobi_heat_stencil_sweep_checker.sv]
// Checker that predicts the swept grid from the input beats and compares the output beats.
module jacobi_heat_stencil_sweep_checker
  import jhs_pkg::*;
  import jhs_tb_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [TEMP_W-1:0]      s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [TEMP_W-1:0]      m_tdata,
  input  logic                   m_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              last;
  } new_cell_t;

  logic [TEMP_W-1:0]      old_cells [0:2*MAX_ROW_WIDTH];
  logic [ROW_WIDTH_W-1:0] row_width;
  logic [ROW_COUNT_W-1:0] row_count;
  int unsigned            feed_row, feed_col, emit_row, emit_col;
  new_cell_t              owed_cells [$];
  int                     errors = 0;

  // Advances the grid by one accepted input beat and queues the cell it releases.
  task automatic sweep_cell(input cell_kind_t kind, input logic [TEMP_W-1:0] temp);
    int unsigned w, h, ring, pos, q, sum;
    new_cell_t   fresh;
    logic        done;
    w = (row_width < 3) ? 3 : ((row_width > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : row_width);
    h = (row_count < 3) ? 3 : row_count;
    ring = 2 * w + 1;
    pos = feed_row * w + feed_col;
    done = (feed_row >= h);
    fresh.last = 1'b0;
    // A flush inside an unfinished grid leaves everything as it is.
    if (kind == KIND_FLUSH && !done) return;
    if (pos >= w + 1) begin
      q = emit_row * w + emit_col;
      if (emit_row == 0 || emit_row == h - 1 || emit_col == 0 || emit_col == w - 1) begin
        fresh.temp = old_cells[q % ring];
      end else begin
        sum = old_cells[(q - w) % ring] + old_cells[(q + w) % ring]
            + old_cells[(q - 1) % ring] + old_cells[(q + 1) % ring];
        fresh.temp = TEMP_W'(sum >> 2);
      end
      fresh.last = (emit_row == h - 1 && emit_col == w - 1);
      owed_cells.push_back(fresh);
      emit_col++;
      if (emit_col >= w) begin
        emit_col = 0;
        emit_row++;
      end
    end
    if (!done && kind == KIND_CELL) old_cells[pos % ring] = temp;
    feed_col++;
    if (feed_col >= w) begin
      feed_col = 0;
      feed_row++;
    end
    if (fresh.last) begin
      feed_row = 0;
      feed_col = 0;
      emit_row = 0;
      emit_col = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    new_cell_t want;
    if (rst) begin
      row_width = ROW_WIDTH_RESET;
      row_count = ROW_COUNT_RESET;
      feed_row = 0;
      feed_col = 0;
      emit_row = 0;
      emit_col = 0;
      owed_cells.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_cells.size() == 0) begin
          $display("%0t: result beat temp_out=%h last=%b with nothing expected",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = owed_cells.pop_front();
          if (m_tdata !== want.temp) begin
            $display("%0t: temp_out expected %h, got %h", $time, want.temp, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last expected %b, got %b", $time, want.last, m_tlast);
            errors++;
          end
        end
      end
      // Any register write restarts the stream; the store keeps its contents.
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ROW_WIDTH) row_width = cfg_data[ROW_WIDTH_W-1:0];
        else row_count = cfg_data[ROW_COUNT_W-1:0];
        feed_row = 0;
        feed_col = 0;
        emit_row = 0;
        emit_col = 0;
      end
      if (s_tvalid && s_tready) sweep_cell(cell_kind_t'(s_tuser), s_tdata);
    end
    mismatches  <= errors;
    outstanding <= owed_cells.size();
  end

endmodule

[tb/jacobi_heat_stencil_sweep_top_test.sv]
// Stimulus and verdict for the Jacobi heat stencil sweep block.
module jacobi_heat_stencil_sweep_top_test;
  import jhs_pkg::*;
  import jhs_tb_pkg::*;

  localparam int SETTLE       = 8;
  localparam int LIMIT        = 150000;
  localparam int RANDOM_ITEMS = 450;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [TEMP_W-1:0]      s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [TEMP_W-1:0]      m_tdata;
  logic                   m_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ROW_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  int                     mismatches;
  int                     outstanding;
  int                     cycles    = 0;
  int                     fed       = 0;
  bit                     calm      = 1'b0;

  jacobi_heat_stencil_sweep_top uut (.*);

  jacobi_heat_stencil_sweep_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("** jacobi_heat_stencil_sweep_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 23);

  function automatic logic [TEMP_W-1:0] pick_temp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return TEMP_W'($urandom);
    endcase
  endfunction

  task automatic push_beat(input cell_kind_t kind, input logic [TEMP_W-1:0] temp);
    while (!calm && $urandom_range(0, 99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= temp;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops sending and waits for every owed result, then for the block to go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] width_val, count_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ROW_WIDTH;
    cfg_data  <= width_val;
    @(posedge clk);
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= count_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends the first cells of a w by h grid, with stray flushes that the block ignores.
  // A complete grid is followed by w+1 beats that drain the delayed cells.
  task automatic feed_grid(input int w, h, cells, input bit hold);
    for (int i = 0; i < cells; i++) begin
      if ($urandom_range(0, 19) == 0) push_beat(KIND_FLUSH, pick_temp());
      if (hold && i == cells / 2) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      push_beat(KIND_CELL, pick_temp());
      fed++;
    end
    if (cells == w * h) begin
      for (int i = 0; i <= w; i++) begin
        push_beat(cell_kind_t'($urandom_range(0, 1)), pick_temp());
        fed++;
      end
    end
  endtask

  initial begin : stimulus
    int                    w, h, cells, g;
    logic [CFG_DATA_W-1:0] wr_w, wr_h;
    logic [TEMP_W-1:0]     plus [9];
    logic [TEMP_W-1:0]     dip [9];

    plus  = '{16'h0000, 16'hFFFF, 16'h0000,
              16'hFFFF, 16'h1234, 16'hFFFF,
              16'h0000, 16'hFFFF, 16'h0000};
    // The center's neighbors sum to three, so its quarter truncates to zero.
    dip   = '{16'hFFFF, 16'h0001, 16'hFFFF,
              16'h0001, 16'hFFFF, 16'h0000,
              16'h8000, 16'h0001, 16'h7FFF};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: a short stub never reaches its first result.
    push_beat(KIND_FLUSH, '1);
    for (int i = 0; i < 4; i++) push_beat(KIND_CELL, pick_temp());
    settle();

    // Sizes below the minimum are used as three.
    configure(16'd0, 16'd2);
    push_beat(KIND_FLUSH, 16'h5A5A);
    foreach (plus[i]) push_beat(KIND_CELL, plus[i]);
    push_beat(KIND_FLUSH, 16'h0000);
    push_beat(KIND_CELL, 16'hFFFF);
    push_beat(KIND_FLUSH, 16'hFFFF);
    push_beat(KIND_CELL, 16'h0000);
    // The grid has ended, so this flush falls at the start of a new one.
    push_beat(KIND_FLUSH, 16'hA5A5);
    foreach (dip[i]) push_beat(KIND_CELL, dip[i]);
    for (int i = 0; i < 4; i++) push_beat(KIND_FLUSH, pick_temp());
    settle();

    fed = 0;
    g = 0;
    while (fed < RANDOM_ITEMS) begin
      w = $urandom_range(3, 9);
      h = $urandom_range(3, 6);
      wr_w = (w == 3 && $urandom_range(0, 3) == 0) ?
             CFG_DATA_W'($urandom_range(0, 2)) : CFG_DATA_W'(w);
      if ($urandom_range(0, 3) == 0) begin
        wr_w[CFG_DATA_W-1:ROW_WIDTH_W] = (CFG_DATA_W-ROW_WIDTH_W)'($urandom);
      end
      wr_h = (h == 3 && $urandom_range(0, 3) == 0) ?
             CFG_DATA_W'($urandom_range(0, 2)) : CFG_DATA_W'(h);
      cells = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h - 1) : w * h;
      calm = (g >= 5 && g < 9);
      configure(wr_w, wr_h);
      feed_grid(w, h, cells, g == 4);
      settle();
      g++;
    end
    calm = 1'b0;

    // Widest grid: an all-ones width saturates at the maximum.
    configure(16'hFFFF, 16'd3);
    feed_grid(MAX_ROW_WIDTH_DEF, 3, 3 * MAX_ROW_WIDTH_DEF, 1'b0);
    settle();

    // Tallest grid, abandoned part way and restarted by the next write.
    configure(16'd3, 16'hFFFF);
    feed_grid(3, 65535, 60, 1'b0);
    settle();
    configure(16'd5, 16'd4);
    feed_grid(5, 4, 20, 1'b0);
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("** jacobi_heat_stencil_sweep_top: PASSED **");
    end else begin
      $display("** jacobi_heat_stencil_sweep_top: FAILED **");
    end
    $finish;
  end

endmodule
